/* sv/bqd_pkg.sv */
// Shared types, format codes and helpers for the block dequantizer.
// No dependencies; imported by bqd_lane and block_quant_dequantizer_top.
`timescale 1ns / 1ps
`default_nettype none
package bqd_pkg;

	// Block format codes held in the format register
	localparam logic [1:0] FMT_Q4_0 = 2'd0;
	localparam logic [1:0] FMT_Q5_0 = 2'd1;
	localparam logic [1:0] FMT_Q4_1 = 2'd2;
	localparam logic [1:0] FMT_Q8_0 = 2'd3;
	localparam logic [1:0] FORMAT_RESET = FMT_Q4_0;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	// Fixed-point datapath: values scaled by 2^24, magnitude below 2^48
	localparam int PROD_W = 19;
	localparam int ACC_W  = 48;
	localparam int MAG_W  = 49;
	localparam int SUM_W  = 50;
	localparam int LZ_W   = 6;
	localparam logic [7:0] EXP_OFFSET = 8'd103;

	// Decoded half-precision operand
	typedef struct packed {
		logic        sgn;
		logic [10:0] mant;
		logic [4:0]  sh;
		logic        inf;
		logic        nan;
	} half_t;

	// Operands for one lane, registered in the first stage
	typedef struct packed {
		half_t      d;
		half_t      m;
		logic       q41;
		logic       csgn;
		logic [7:0] cmag;
	} lane_in_t;

	function automatic half_t half_dec(input logic [15:0] h);
		half_t r;
		r.sgn  = h[15];
		r.mant = {h[14:10] != 5'd0, h[9:0]};
		r.sh   = (h[14:10] == 5'd0) ? 5'd0 : h[14:10] - 5'd1;
		r.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
		r.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
		return r;
	endfunction

	// Signed element code for the selected format
	function automatic logic signed [8:0] code_of(input logic [1:0] fmt,
			input logic [3:0] nib, input logic hb, input logic [7:0] byt);
		logic signed [8:0] c;
		case (fmt)
			FMT_Q4_0: c = $signed({5'b0, nib}) - 9'sd8;
			FMT_Q5_0: c = $signed({4'b0, hb, nib}) - 9'sd16;
			FMT_Q4_1: c = $signed({5'b0, nib});
			default:  c = $signed({byt[7], byt});
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/bqd_lane.sv */
// One dequantizing lane: d*code (+m for Q4_1) to float32, stages 2 to 7.
// Depends on bqd_pkg; its inputs are the first-stage registers of the top.
`timescale 1ns / 1ps
`default_nettype none
module bqd_lane (
	input  wire              clk,
	input  wire bqd_pkg::lane_in_t op_s1,
	output logic [31:0]      value_s7
);
	import bqd_pkg::*;

	typedef struct packed {
		logic nan;
		logic inf;
		logic inf_sgn;
		logic zero_sgn;
	} spec_t;

	logic [PROD_W-1:0] prod_s2;
	lane_in_t          op_s2;
	spec_t             spec_s2, spec_s3, spec_s4, spec_s5, spec_s6;
	logic [ACC_W-1:0]  a_s3, b_s3;
	logic              sa_s3, sb_s3;
	logic [SUM_W-1:0]  sum_s4;
	logic [MAG_W-1:0]  mag_s5, mag_s6;
	logic              sgn_s5, sgn_s6, zero_s5, zero_s6;
	logic [LZ_W-1:0]   k_s6;

	logic              psgn, pzero;
	spec_t             spec_c;
	logic [SUM_W-1:0]  a_ext, b_ext;
	logic [MAG_W-1:0]  abs_c;
	logic [LZ_W-1:0]   k_c;
	logic [MAG_W-1:0]  norm_c;
	logic [31:0]       pack_c;
	logic              rup_c;

	// Classify special results from the raw operands
	always_comb begin
		psgn  = op_s1.d.sgn ^ op_s1.csgn;
		pzero = (op_s1.d.mant == 11'd0) || (op_s1.cmag == 8'd0);
		spec_c.nan = op_s1.d.nan || (op_s1.d.inf && op_s1.cmag == 8'd0)
			|| (op_s1.q41 && op_s1.m.nan)
			|| (op_s1.q41 && op_s1.d.inf && op_s1.m.inf && (psgn != op_s1.m.sgn));
		spec_c.inf = op_s1.d.inf || (op_s1.q41 && op_s1.m.inf);
		spec_c.inf_sgn = op_s1.d.inf ? psgn : op_s1.m.sgn;
		spec_c.zero_sgn = op_s1.q41
			? (pzero && op_s1.m.mant == 11'd0 && psgn && op_s1.m.sgn) : psgn;
	end

	// Stage 2: exact significand product
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(op_s1.d.mant * op_s1.cmag);
		op_s2   <= op_s1;
		spec_s2 <= spec_c;
	end

	// Stage 3: align both terms to the 2^-24 grid
	always_ff @(posedge clk) begin
		a_s3    <= ACC_W'(prod_s2) << op_s2.d.sh;
		b_s3    <= op_s2.q41 ? (ACC_W'(op_s2.m.mant) << op_s2.m.sh) : '0;
		sa_s3   <= op_s2.d.sgn ^ op_s2.csgn;
		sb_s3   <= op_s2.m.sgn;
		spec_s3 <= spec_s2;
	end

	// Stage 4: signed sum
	always_comb begin
		a_ext = SUM_W'(a_s3);
		b_ext = SUM_W'(b_s3);
	end

	always_ff @(posedge clk) begin
		sum_s4  <= (sa_s3 ? -a_ext : a_ext) + (sb_s3 ? -b_ext : b_ext);
		spec_s4 <= spec_s3;
	end

	// Stage 5: sign and magnitude
	always_comb begin
		abs_c = sum_s4[SUM_W-1] ? MAG_W'(-sum_s4) : MAG_W'(sum_s4);
	end

	always_ff @(posedge clk) begin
		mag_s5  <= abs_c;
		sgn_s5  <= sum_s4[SUM_W-1];
		zero_s5 <= (sum_s4 == '0);
		spec_s5 <= spec_s4;
	end

	// Stage 6: find the leading one
	always_comb begin
		k_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag_s5[i]) begin
				k_c = LZ_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s6  <= mag_s5;
		k_s6    <= k_c;
		sgn_s6  <= sgn_s5;
		zero_s6 <= zero_s5;
		spec_s6 <= spec_s5;
	end

	// Stage 7: normalise, round to nearest even, pack
	always_comb begin
		norm_c = mag_s6 << (LZ_W'(MAG_W - 1) - k_s6);
		pack_c = {sgn_s6, {2'b0, k_s6} + EXP_OFFSET, norm_c[MAG_W-2:MAG_W-24]};
		rup_c  = norm_c[MAG_W-25] && ((|norm_c[MAG_W-26:0]) || norm_c[MAG_W-24]);
	end

	always_ff @(posedge clk) begin
		if (spec_s6.nan) begin
			value_s7 <= CANON_NAN;
		end else if (spec_s6.inf) begin
			value_s7 <= {spec_s6.inf_sgn, 8'hFF, 23'd0};
		end else if (zero_s6) begin
			value_s7 <= {spec_s6.zero_sgn, 31'd0};
		end else begin
			value_s7 <= pack_c + {31'd0, rup_c};
		end
	end

endmodule
`default_nettype wire

/* sv/block_quant_dequantizer_top.sv */
// Top level of the block dequantizer: command port, two lanes, output word.
// Depends on bqd_pkg and bqd_lane.
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+------------------
//  input    | scale_bits min_bits data_byte high_low          | start & !busy
//           | high_high position last_in                      |
//  result   | value_bits element_index last_out               | done, one cycle
//  config   | cfg_wdata (format)                              | cfg_we
//
// The first result word follows an accept through seven stages and the output
// register. Q8_0 accepts one item per cycle; nibble formats cannot, as both
// words share the single result port and busy is high for the cycle after
// each nibble-format accept. Reset clears all valid bits and sets the format
// to Q4_0. The receiver cannot stall, so the result side has no back-pressure.
`timescale 1ns / 1ps
`default_nettype none
module block_quant_dequantizer_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_wdata,
	input  wire         start,
	output logic        busy,
	input  wire  [15:0] scale_bits,
	input  wire  [15:0] min_bits,
	input  wire  [7:0]  data_byte,
	input  wire         high_low,
	input  wire         high_high,
	input  wire  [4:0]  position,
	input  wire         last_in,
	output logic        done,
	output logic [31:0] value_bits,
	output logic [4:0]  element_index,
	output logic        last_out
);
	import bqd_pkg::*;

	localparam int NSTG = 7;

	typedef struct packed {
		logic       pair;
		logic [4:0] pos;
		logic       last;
	} ctl_t;

	logic [1:0]  format_q;
	logic        pair_q;
	logic        accept;
	logic [NSTG:1] vld_s;
	ctl_t        ctl_s [1:NSTG];
	lane_in_t    opa_s1, opb_s1;
	lane_in_t    opa_c, opb_c;
	logic signed [8:0] ca_c, cb_c;
	logic [31:0] va_s7, vb_s7;
	logic        pend_q;
	logic [31:0] pend_val_q;
	logic [4:0]  pend_idx_q;
	logic        pend_last_q;

	assign accept = start && !busy;
	assign busy   = pair_q;

	// Hold the format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FORMAT_RESET;
		end else if (cfg_we) begin
			format_q <= cfg_wdata;
		end
	end

	// Block the cycle after a two-word item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= 1'b0;
		end else begin
			pair_q <= accept && (format_q != FMT_Q8_0);
		end
	end

	// Decode operands for both lanes
	always_comb begin
		ca_c = code_of(format_q, data_byte[3:0], high_low, data_byte);
		cb_c = code_of(format_q, data_byte[7:4], high_high, data_byte);
		opa_c.d    = half_dec(scale_bits);
		opa_c.m    = half_dec(min_bits);
		opa_c.q41  = (format_q == FMT_Q4_1);
		opa_c.csgn = ca_c[8];
		opa_c.cmag = ca_c[8] ? 8'(-ca_c) : ca_c[7:0];
		opb_c      = opa_c;
		opb_c.csgn = cb_c[8];
		opb_c.cmag = cb_c[8] ? 8'(-cb_c) : cb_c[7:0];
	end

	// Stage 1 payload, and advance control alongside the lanes
	always_ff @(posedge clk) begin
		if (accept) begin
			opa_s1 <= opa_c;
			opb_s1 <= opb_c;
			ctl_s[1] <= '{pair: (format_q != FMT_Q8_0), pos: position, last: last_in};
		end
		for (int i = 2; i <= NSTG; i++) begin
			ctl_s[i] <= ctl_s[i-1];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NSTG-1:1], accept};
		end
	end

	bqd_lane u_lane_a (
		.clk      (clk),
		.op_s1    (opa_s1),
		.value_s7 (va_s7)
	);

	bqd_lane u_lane_b (
		.clk      (clk),
		.op_s1    (opb_s1),
		.value_s7 (vb_s7)
	);

	// Output word: the high element follows in the cycle after the low one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done   <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			done   <= pend_q || vld_s[NSTG];
			pend_q <= !pend_q && vld_s[NSTG] && ctl_s[NSTG].pair;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			value_bits    <= pend_val_q;
			element_index <= pend_idx_q;
			last_out      <= pend_last_q;
		end else begin
			value_bits    <= va_s7;
			element_index <= ctl_s[NSTG].pair ? {1'b0, ctl_s[NSTG].pos[3:0]}
				: ctl_s[NSTG].pos;
			last_out      <= ctl_s[NSTG].pair ? 1'b0 : ctl_s[NSTG].last;
		end
		pend_val_q  <= vb_s7;
		pend_idx_q  <= {1'b1, ctl_s[NSTG].pos[3:0]};
		pend_last_q <= ctl_s[NSTG].last;
	end

endmodule
`default_nettype wire

/* sv/bqd_checker.sv */
// Port-level checks for block_quant_dequantizer_top, attached by bind.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module bqd_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       start,
	input wire       busy,
	input wire       done,
	input wire [4:0] element_index
);

	// Busy lasts one cycle and follows an accept
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("busy held for more than one cycle");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $past(start && !busy)) else $error("busy without an accept");

	// Every accepted word yields a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##8 done) else $error("result word missing");

	// A two-word item gives its high element straight after the low one
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) ##1 busy |-> ##7 (done && !element_index[4]) ##1
		(done && element_index[4])) else $error("element pair out of order");

endmodule

bind block_quant_dequantizer_top bqd_checker u_bqd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.element_index (element_index)
);
`default_nettype wire

/* tb/sv/block_quant_dequantizer_top_tb.sv */
// Self-checking testbench for block_quant_dequantizer_top: directed and random byte
// words in every block format, with results checked against a float model of the block.
// Depends on bqd_pkg and the block_quant_dequantizer_top RTL.
`timescale 1ns / 1ps
`default_nettype none
module block_quant_dequantizer_top_tb;
	import bqd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] scale_bits = '0;
	logic [15:0] min_bits = '0;
	logic [7:0]  data_byte = '0;
	logic        high_low = 1'b0;
	logic        high_high = 1'b0;
	logic [4:0]  position = '0;
	logic        last_in = 1'b0;
	logic        done;
	logic [31:0] value_bits;
	logic [4:0]  element_index;
	logic        last_out;
	int          cycles = 0;

	typedef struct packed {
		logic [31:0] value;
		logic [4:0]  index;
		logic        last;
	} weight_t;

	// Widen half bits to double bits; every half is exact in double
	function automatic logic [63:0] half_to_double(input logic [15:0] h);
		logic [4:0]  ex;
		logic [10:0] man;
		int          e;
		ex = h[14:10];
		man = {1'b0, h[9:0]};
		if (ex == 5'd31)
			return {h[15], 11'h7FF, h[9:0], 42'b0};
		if (ex != 5'd0)
			return {h[15], 11'(ex + 1008), h[9:0], 42'b0};
		if (man == 11'd0)
			return {h[15], 63'b0};
		e = -14;
		while (!man[10]) begin
			man = man << 1;
			e--;
		end
		return {h[15], 11'(e + 1023), man[9:0], 42'b0};
	endfunction

	// Round a double to single bits, nearest even; NaN made canonical
	function automatic logic [31:0] double_to_single(input real r);
		logic [63:0] b;
		logic [30:0] mag;
		b = $realtobits(r);
		if (b[62:52] == 11'h7FF)
			return (b[51:0] != 0) ? CANON_NAN : {b[63], 8'hFF, 23'b0};
		if (b[62:52] == 11'd0)
			return {b[63], 31'b0};
		mag = {8'(b[62:52] - 11'd896), b[51:29]};
		if (b[28] && ((|b[27:0]) || b[29]))
			mag = mag + 31'd1;
		return {b[63], mag};
	endfunction

	class weight_scoreboard;
		logic [1:0] format_reg;
		weight_t    pending[$];
		int         errors;

		function new();
			format_reg = FORMAT_RESET;
			errors = 0;
		endfunction

		task report(input string what);
			$display("mismatch @%0t: %s", $realtime, what);
			errors++;
		endtask

		// Work out the weights one accepted byte word yields
		function void note(input logic [15:0] sc, input logic [15:0] mn,
				input logic [7:0] byt, input logic hl, input logic hh,
				input logic [4:0] pos, input logic lst);
			real     d, m, lo_v, hi_v;
			int      lo_c, hi_c;
			weight_t w;
			d = $bitstoreal(half_to_double(sc));
			m = $bitstoreal(half_to_double(mn));
			case (format_reg)
				FMT_Q8_0: begin
					w.value = double_to_single(d * $itor($signed(byt)));
					w.index = pos;
					w.last = lst;
					pending.push_back(w);
					return;
				end
				FMT_Q4_0: begin
					lo_c = int'(byt[3:0]) - 8;
					hi_c = int'(byt[7:4]) - 8;
				end
				FMT_Q5_0: begin
					lo_c = int'({hl, byt[3:0]}) - 16;
					hi_c = int'({hh, byt[7:4]}) - 16;
				end
				default: begin
					lo_c = int'(byt[3:0]);
					hi_c = int'(byt[7:4]);
				end
			endcase
			lo_v = d * $itor(lo_c);
			hi_v = d * $itor(hi_c);
			if (format_reg == FMT_Q4_1) begin
				lo_v = lo_v + m;
				hi_v = hi_v + m;
			end
			w.value = double_to_single(lo_v);
			w.index = {1'b0, pos[3:0]};
			w.last = 1'b0;
			pending.push_back(w);
			w.value = double_to_single(hi_v);
			w.index = {1'b1, pos[3:0]};
			w.last = lst;
			pending.push_back(w);
		endfunction

		task check(input logic [31:0] v, input logic [4:0] idx,
				input logic lst);
			weight_t w;
			if (pending.size() == 0) begin
				report($sformatf("unexpected word %h idx %0d", v, idx));
				return;
			end
			w = pending.pop_front();
			if (v !== w.value)
				report($sformatf("value %h, want %h (idx %0d)", v, w.value, w.index));
			if (idx !== w.index)
				report($sformatf("element_index %0d, want %0d", idx, w.index));
			if (lst !== w.last)
				report($sformatf("last_out %b, want %b", lst, w.last));
		endtask
	endclass

	weight_scoreboard sb;

	block_quant_dequantizer_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .scale_bits(scale_bits), .min_bits(min_bits),
		.data_byte(data_byte), .high_low(high_low), .high_high(high_high),
		.position(position), .last_in(last_in), .done(done),
		.value_bits(value_bits), .element_index(element_index), .last_out(last_out)
	);

	always #5 clk = ~clk;

	// Check each result word in the cycle it is shown
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check(value_bits, element_index, last_out);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** block_quant_dequantizer_top: FAILED **");
			$finish;
		end
	end

	// Present one byte word and hold it until accepted, then maybe idle
	task automatic send_byte(input logic [15:0] sc, input logic [15:0] mn,
			input logic [7:0] byt, input logic hl, input logic hh,
			input logic [4:0] pos, input logic lst, input bit may_idle);
		start <= 1'b1;
		scale_bits <= sc;
		min_bits <= mn;
		data_byte <= byt;
		high_low <= hl;
		high_high <= hh;
		position <= pos;
		last_in <= lst;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note(sc, mn, byt, hl, hh, pos, lst);
		if (may_idle && $urandom_range(99) < 9) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Drain, then write the format register while idle
	task automatic set_format(input logic [1:0] f);
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.format_reg = f;
	endtask

	// Half value with a bias towards zero, subnormal, infinity, NaN and largest finite codes
	function automatic logic [15:0] pick_half();
		case ($urandom_range(15))
			0: return {1'($urandom_range(1)), 15'h0000};
			1: return {1'($urandom_range(1)), 5'd0, 10'($urandom)};
			2: return {1'($urandom_range(1)), 15'h7C00};
			3: return {1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1, 1023))};
			4: return {1'($urandom_range(1)), 15'h7BFF};
			default: return 16'($urandom);
		endcase
	endfunction

	logic [1:0] plan[8] = '{FMT_Q4_0, FMT_Q5_0, FMT_Q4_1, FMT_Q8_0,
		FMT_Q4_1, FMT_Q8_0, FMT_Q4_0, FMT_Q5_0};

	initial begin
		int n;
		logic [4:0] pos;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: field extremes under reset format, Q4_0
		send_byte(16'h3C00, 16'h0000, 8'h00, 1'b0, 1'b0, 5'd0, 1'b0, 0);
		send_byte(16'h3C00, 16'h0000, 8'hFF, 1'b1, 1'b1, 5'd15, 1'b0, 0);
		send_byte(16'h7BFF, 16'hFBFF, 8'h0F, 1'b0, 1'b1, 5'd31, 1'b1, 0);
		send_byte(16'h0001, 16'h8001, 8'hF0, 1'b1, 1'b0, 5'd16, 1'b0, 0);
		send_byte(16'h7C00, 16'h0000, 8'h88, 1'b0, 1'b0, 5'd7, 1'b0, 0);
		send_byte(16'hFE01, 16'h7E00, 8'h5A, 1'b0, 1'b0, 5'd3, 1'b1, 0);
		send_byte(16'h8000, 16'h0000, 8'h37, 1'b0, 1'b0, 5'd9, 1'b0, 0);
		for (int p = 0; p < 8; p++) begin
			set_format(plan[p]);
			// Directed per format: zero code, infinities times zero, NaN, minimum
			send_byte(16'h7C00, 16'hFC00, 8'h08, 1'b1, 1'b1, 5'd31, 1'b0, 0);
			send_byte(16'hFC00, 16'h7C00, 8'h80, 1'b0, 1'b1, 5'd17, 1'b1, 0);
			send_byte(16'h3555, 16'h0203, 8'h7F, 1'b1, 1'b0, 5'd5, 1'b0, 0);
			send_byte(16'h8000, 16'h8000, 8'h00, 1'b0, 1'b0, 5'd0, 1'b1, 0);
			send_byte(16'h1234, 16'h7E55, 8'hC3, 1'b1, 1'b1, 5'd14, 1'b0, 0);
			// Random rows of 16 or 32 bytes, the odd one jumbled
			n = 0;
			while (n < 170) begin
				logic [15:0] sc, mn;
				int row_len;
				bit jumble;
				row_len = (plan[p] == FMT_Q8_0) ? 32 : 16;
				jumble = ($urandom_range(9) == 0);
				sc = pick_half();
				mn = pick_half();
				for (int k = 0; k < row_len; k++) begin
					pos = jumble ? 5'($urandom) : 5'(k);
					send_byte(sc, mn, 8'($urandom), 1'($urandom), 1'($urandom), pos,
						jumble ? 1'($urandom) : (k == row_len - 1), p != 4);
					n++;
				end
			end
		end
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("** block_quant_dequantizer_top: PASSED **");
		else
			$display("** block_quant_dequantizer_top: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
sv/bqd_pkg.sv
sv/bqd_lane.sv
sv/block_quant_dequantizer_top.sv
sv/bqd_checker.sv
tb/sv/block_quant_dequantizer_top_tb.sv
